/* sv/pdfc_pkg.sv */
`default_nettype none

package pdfc_pkg;

  localparam int unsigned LIMIT_W = 17;
  localparam logic [LIMIT_W-1:0] HARD_CAP = 17'd70000;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd1024;

  localparam logic [7:0] TYPE_DATA = 8'h01;
  localparam logic [7:0] TYPE_CONNECT = 8'h02;
  localparam logic [7:0] TYPE_ATTACH = 8'h03;
  localparam logic [7:0] TYPE_DETACH = 8'h04;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_LINK_LOST = 1'b1;

  typedef enum logic [2:0] {
    PH_TYPE = 3'd0,
    PH_LEN0 = 3'd1,
    PH_LEN1 = 3'd2,
    PH_LEN2 = 3'd3,
    PH_LEN3 = 3'd4,
    PH_DATA = 3'd5,
    PH_SUM  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    ST_PAYLOAD  = 2'd0,
    ST_OK       = 2'd1,
    ST_CSUM_ERR = 2'd2,
    ST_LEN_ERR  = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] payload_byte;
    logic [7:0] frame_type;
    logic       link_connected;
    logic       send_ack;
  } pdfc_result_t;

endpackage

`default_nettype wire

/* sv/pdfc_parser.sv */
`default_nettype none

module pdfc_parser
  import pdfc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic               kind,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [LIMIT_W-1:0] limit,
  output logic                    res_valid,
  output pdfc_result_t            res,
  output logic                    conn_flag
);

  phase_t             phase, phase_next;
  logic [7:0]         type_reg, type_reg_next;
  logic [23:0]        length_acc, length_acc_next;
  logic [LIMIT_W-1:0] bytes_left, bytes_left_next;
  logic [7:0]         running_sum, running_sum_next;
  logic               conn_next;

  logic [7:0]         sum_plus;
  logic [31:0]        full_len;
  logic [LIMIT_W-1:0] left_dec;

  assign sum_plus = running_sum + rx_byte;
  assign full_len = {rx_byte, length_acc};
  assign left_dec = bytes_left - LIMIT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_TYPE;
      type_reg    <= 8'd0;
      length_acc  <= 24'd0;
      bytes_left  <= '0;
      running_sum <= 8'd0;
      conn_flag   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      type_reg    <= type_reg_next;
      length_acc  <= length_acc_next;
      bytes_left  <= bytes_left_next;
      running_sum <= running_sum_next;
      conn_flag   <= conn_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    type_reg_next    = type_reg;
    length_acc_next  = length_acc;
    bytes_left_next  = bytes_left;
    running_sum_next = running_sum;
    conn_next        = conn_flag;
    res_valid        = 1'b0;
    res.status       = ST_PAYLOAD;
    res.payload_byte = 8'd0;
    res.send_ack     = 1'b0;

    if (kind == KIND_LINK_LOST) begin
      phase_next       = PH_TYPE;
      type_reg_next    = 8'd0;
      length_acc_next  = 24'd0;
      bytes_left_next  = '0;
      running_sum_next = 8'd0;
      conn_next        = 1'b0;
    end else begin
      case (phase)
        PH_LEN0: begin
          length_acc_next[7:0] = rx_byte;
          running_sum_next     = sum_plus;
          phase_next           = PH_LEN1;
        end
        PH_LEN1: begin
          length_acc_next[15:8] = rx_byte;
          running_sum_next      = sum_plus;
          phase_next            = PH_LEN2;
        end
        PH_LEN2: begin
          length_acc_next[23:16] = rx_byte;
          running_sum_next       = sum_plus;
          phase_next             = PH_LEN3;
        end
        PH_LEN3: begin
          running_sum_next = sum_plus;
          if (full_len > {{(32-LIMIT_W){1'b0}}, limit}) begin
            res_valid  = 1'b1;
            res.status = ST_LEN_ERR;
            phase_next = PH_TYPE;
          end else begin
            bytes_left_next = full_len[LIMIT_W-1:0];
            phase_next      = (full_len[LIMIT_W-1:0] == '0) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          running_sum_next = sum_plus;
          bytes_left_next  = left_dec;
          if (left_dec == '0) begin
            phase_next = PH_SUM;
          end
          if (type_reg == TYPE_DATA) begin
            res_valid        = 1'b1;
            res.status       = ST_PAYLOAD;
            res.payload_byte = rx_byte;
          end
        end
        PH_SUM: begin
          phase_next = PH_TYPE;
          res_valid  = 1'b1;
          if (rx_byte != running_sum) begin
            res.status = ST_CSUM_ERR;
          end else begin
            res.status = ST_OK;
            if (type_reg == TYPE_CONNECT) begin
              conn_next    = 1'b1;
              res.send_ack = 1'b1;
            end else if (type_reg == TYPE_ATTACH) begin
              conn_next = 1'b1;
            end else if (type_reg == TYPE_DETACH) begin
              conn_next = 1'b0;
            end
          end
        end
        default: begin
          // type byte; the spare phase code lands here too
          type_reg_next    = rx_byte;
          running_sum_next = rx_byte;
          length_acc_next  = 24'd0;
          bytes_left_next  = '0;
          phase_next       = PH_LEN0;
        end
      endcase
    end

    res.frame_type     = type_reg;
    res.link_connected = conn_next;
  end

endmodule

`default_nettype wire

/* sv/packet_deframer_with_checksum.sv */
// Type-length-value frame parser with an 8-bit sum checksum.
// Input channel (in_valid/in_stall): one transaction per received byte
// (kind = 0) or link-lost event (kind = 1). Output channel
// (out_valid/out_stall): at most one result per input transaction: a
// payload byte of a type-1 frame, frame ok, checksum error, or length too
// large (reported on the last length byte).
// Config channel (cfg_valid/cfg_ready): writes max_payload; always ready,
// values above 70000 are stored as 70000. Write only while idle.
// A result passes from the input register, which takes its input at the
// accepting edge, to the output register, which the parser step loads
// from it unless the output is blocked.
// Throughput: one input transaction per cycle while the output is not
// stalled; a type byte may follow the previous frame's last byte directly.
// Reset (rst, synchronous): parser waits for a type byte, link flag clear,
// max_payload = 1024, both pipeline registers empty.
// A stall on the output holds the result; the input register then fills
// and in_stall rises until the result is taken.
`default_nettype none

module packet_deframer_with_checksum
  import pdfc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               kind,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [7:0]              payload_byte,
  output logic [7:0]              frame_type,
  output logic                    link_connected,
  output logic                    send_ack,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [LIMIT_W-1:0] cfg_data
);

  logic               s1_valid;
  logic               s1_kind;
  logic [7:0]         s1_byte;
  logic               out_blocked;
  logic               proc;
  logic [LIMIT_W-1:0] payload_limit;
  logic               res_valid;
  pdfc_result_t       res;
  pdfc_result_t       out_q;
  logic               conn_flag;

  assign out_blocked = out_valid && out_stall;
  assign proc        = s1_valid && !out_blocked;
  assign in_stall    = s1_valid && out_blocked;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      payload_limit <= (cfg_data > HARD_CAP) ? HARD_CAP : cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind <= kind;
      s1_byte <= rx_byte;
    end
  end

  pdfc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (proc),
    .kind      (s1_kind),
    .rx_byte   (s1_byte),
    .limit     (payload_limit),
    .res_valid (res_valid),
    .res       (res),
    .conn_flag (conn_flag)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && res_valid) begin
      out_q <= res;
    end
  end

  assign status         = out_q.status;
  assign payload_byte   = out_q.payload_byte;
  assign frame_type     = out_q.frame_type;
  assign link_connected = out_q.link_connected;
  assign send_ack       = out_q.send_ack;

  a_ack_good_connect: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_ack |-> status == ST_OK && frame_type == TYPE_CONNECT && link_connected)
    else $error("ack without a good connect frame");

  a_link_lost_clears: assert property (@(posedge clk) disable iff (rst)
    proc && s1_kind == KIND_LINK_LOST |=> !conn_flag)
    else $error("link flag survived a link-lost event");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

/* tb/testbench.sv */
`default_nettype none

module testbench;
  import pdfc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 950;
  localparam int PHASE_ITEMS = 130;
  localparam int SETTLE = 6;

  // Tracks the parser byte by byte and keeps the results it should produce, oldest first.
  class deframer_scoreboard;
    phase_t       parse_ph;
    logic [7:0]   cur_type;
    logic [31:0]  len_acc;
    logic [16:0]  left;
    logic [7:0]   csum;
    logic         linked;
    logic [16:0]  max_len;
    pdfc_result_t expected_results[$];
    int           errors;

    function new();
      clear_parse();
      linked = 1'b0;
      max_len = LIMIT_RESET;
      errors = 0;
    endfunction

    function void clear_parse();
      parse_ph = PH_TYPE;
      cur_type = 8'h00;
      len_acc = 32'h0;
      left = 17'h0;
      csum = 8'h00;
    endfunction

    function void set_limit(input logic [16:0] v);
      max_len = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void post(input status_t st, input logic [7:0] pb, input logic ack);
      pdfc_result_t r;
      r.status = st;
      r.payload_byte = pb;
      r.frame_type = cur_type;
      r.link_connected = linked;
      r.send_ack = ack;
      expected_results.push_back(r);
    endfunction

    function void note_input(input logic k, input logic [7:0] b);
      logic [16:0] cap;
      cap = (max_len < HARD_CAP) ? max_len : HARD_CAP;
      if (k == KIND_LINK_LOST) begin
        clear_parse();
        linked = 1'b0;
        return;
      end
      case (parse_ph)
        PH_LEN0, PH_LEN1, PH_LEN2, PH_LEN3: begin
          len_acc = len_acc | (32'(b) << (8 * (parse_ph - PH_LEN0)));
          csum = csum + b;
          if (parse_ph != PH_LEN3) begin
            parse_ph = phase_t'(parse_ph + 1);
          end else if (len_acc > 32'(cap)) begin
            post(ST_LEN_ERR, 8'h00, 1'b0);
            parse_ph = PH_TYPE;
          end else begin
            left = len_acc[16:0];
            parse_ph = (left == 17'h0) ? PH_SUM : PH_DATA;
          end
        end
        PH_DATA: begin
          csum = csum + b;
          left = left - 17'd1;
          if (left == 17'h0) parse_ph = PH_SUM;
          if (cur_type == TYPE_DATA) post(ST_PAYLOAD, b, 1'b0);
        end
        PH_SUM: begin
          parse_ph = PH_TYPE;
          if (b != csum) begin
            post(ST_CSUM_ERR, 8'h00, 1'b0);
          end else begin
            case (cur_type)
              TYPE_CONNECT, TYPE_ATTACH: linked = 1'b1;
              TYPE_DETACH: linked = 1'b0;
              default: ;
            endcase
            post(ST_OK, 8'h00, cur_type == TYPE_CONNECT);
          end
        end
        default: begin
          // anything else waits for a type byte
          cur_type = b;
          csum = b;
          len_acc = 32'h0;
          left = 17'h0;
          parse_ph = PH_LEN0;
        end
      endcase
    endfunction

    function void field_check(input string what, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void check_result(input pdfc_result_t got);
      pdfc_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, got status %0h type %0h",
                 $time, got.status, got.frame_type);
        return;
      end
      want = expected_results.pop_front();
      field_check("status", 8'(want.status), 8'(got.status));
      field_check("payload_byte", want.payload_byte, got.payload_byte);
      field_check("frame_type", want.frame_type, got.frame_type);
      field_check("link_connected", 8'(want.link_connected), 8'(got.link_connected));
      field_check("send_ack", 8'(want.send_ack), 8'(got.send_ack));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               kind;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [7:0]         payload_byte;
  logic [7:0]         frame_type;
  logic               link_connected;
  logic               send_ack;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  deframer_scoreboard sb;
  bit                 steady = 1'b0;
  int                 items_sent = 0;
  int                 cycle_count = 0;
  logic [16:0]        cur_limit = LIMIT_RESET;

  packet_deframer_with_checksum i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .payload_byte   (payload_byte),
    .frame_type     (frame_type),
    .link_connected (link_connected),
    .send_ack       (send_ack),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    pdfc_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.status = status_t'(status);
      got.payload_byte = payload_byte;
      got.frame_type = frame_type;
      got.link_connected = link_connected;
      got.send_ack = send_ack;
      sb.check_result(got);
    end
  end

  // result side: random stall before each transaction
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = steady ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [16:0] eff_limit();
    return (cur_limit < HARD_CAP) ? cur_limit : HARD_CAP;
  endfunction

  task automatic send_item(input logic k, input logic [7:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_input(k, b);
    items_sent++;
  endtask

  // bytes go out MSB first
  task automatic send_packed(input logic [63:0] bytes, input int n);
    for (int i = 0; i < n; i++)
      send_item(KIND_BYTE, bytes[8*(n-1-i) +: 8]);
  endtask

  // wait out all results plus the pipeline, sender idle
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [16:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
    cur_limit = v;
  endtask

  // cut >= 0 replaces that byte and the rest of the frame with a link-lost event
  task automatic send_frame(input logic [7:0] ftype, input logic [31:0] len, input bit sum_ok,
                            input int cut);
    logic [7:0] seq[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    seq.push_back(ftype);
    sum = ftype;
    for (int i = 0; i < 4; i++) begin
      b = len[8*i +: 8];
      seq.push_back(b);
      sum = sum + b;
    end
    if (len <= 32'(eff_limit())) begin
      n = len;
      repeat (n) begin
        b = 8'($urandom_range(0, 255));
        seq.push_back(b);
        sum = sum + b;
      end
      seq.push_back(sum_ok ? sum : 8'(sum + 8'($urandom_range(1, 255))));
    end
    foreach (seq[i]) begin
      if (i == cut) begin
        send_item(KIND_LINK_LOST, 8'($urandom_range(0, 255)));
        return;
      end
      send_item(KIND_BYTE, seq[i]);
    end
  endtask

  task automatic random_frame();
    logic [7:0]  ftype;
    logic [31:0] len;
    logic [16:0] eff;
    int          r;
    int          cut;
    eff = eff_limit();
    r = $urandom_range(0, 99);
    if (r < 40) ftype = TYPE_DATA;
    else if (r < 55) ftype = TYPE_CONNECT;
    else if (r < 65) ftype = TYPE_ATTACH;
    else if (r < 75) ftype = TYPE_DETACH;
    else ftype = 8'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(0, (eff < 12) ? 32'(eff) : 32'd12);
    else if (r < 80) len = (eff <= 64) ? 32'(eff) : $urandom_range(0, 12);
    else if (r < 88) len = 32'(eff) + 32'd1;
    else if (r < 92) len = $urandom_range(70001, 131071);
    else if (r < 95) len = $urandom;
    else len = (eff >= 13) ? $urandom_range(13, (eff < 300) ? 32'(eff) : 32'd300) : 32'(eff);
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 6) : -1;
    send_frame(ftype, len, $urandom_range(0, 99) < 85, cut);
  endtask

  task automatic line_noise();
    repeat ($urandom_range(1, 4))
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 1)
      send_item(KIND_LINK_LOST, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [16:0] pick_limit(input int p);
    case (p % 6)
      0: return 17'd0;
      1: return '1;
      2: return HARD_CAP;
      3: return 17'($urandom_range(1, 40));
      4: return 17'($urandom_range(0, 131071));
      default: return 17'($urandom_range(41, 2000));
    endcase
  endfunction

  initial begin
    int p;
    int r;
    int start;
    sb = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_BYTE;
    rx_byte <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // data frame with payload 00 FF and a bad checksum
    send_packed({TYPE_DATA, 8'h02, 24'h0, 8'h00, 8'hFF, 8'h03}, 8);
    // connect, zero length: ack
    send_packed(64'({TYPE_CONNECT, 32'h0, 8'h02}), 6);
    // detach, zero length: flag clears
    send_packed(64'({TYPE_DETACH, 32'h0, 8'h04}), 6);
    // length 1025 over the reset limit of 1024
    send_packed(64'({TYPE_ATTACH, 8'h01, 8'h04, 16'h0}), 5);
    send_item(KIND_LINK_LOST, 8'hFF);

    p = 0;
    while (items_sent < ITEM_TARGET) begin
      settle_idle();
      write_limit(pick_limit(p));
      steady = ($urandom_range(0, 3) == 0);
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS && items_sent < ITEM_TARGET) begin
        r = $urandom_range(0, 99);
        if (r < 85) random_frame();
        else if (r < 95) line_noise();
        else if (r < 97) settle_idle();
        else send_item(KIND_LINK_LOST, 8'($urandom_range(0, 255)));
      end
      p++;
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
